/* hw/rtl/thfs_pkg.sv */
// Shared constants for the two-hop friend suggestion unit.
`default_nettype none

package thfs_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W = 64;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 72;
    localparam logic [CNT_W-1:0] NODE_COUNT_RESET = CNT_W'(MAX_NODES);

endpackage

`default_nettype wire

/* hw/rtl/two_hop_friend_suggestions_unit.sv */
// Two-hop friend suggestion unit: adjacency store, two-hop sweep and transpose gather.
// Load: one row beat per cycle in S_LOAD; s_tready is low from the last row beat until the
// last result beat enters the output register, which it may leave after loading resumes.
// Pass one builds each two-hop row into sug_mem; pass two gathers each output row from it
// and its transpose, waiting in S_BEMIT while the output register is full and stalled.
// Reset: control state cleared, node_count set to 64; memories are not cleared.
`default_nettype none

module two_hop_friend_suggestions_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [thfs_pkg::CNT_W-1:0]      cfg_wr_data,   // node_count
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [5:0] row_index, [69:6] friend_bits, [71:70] zero
    input  wire logic [thfs_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                            s_tlast,       // last_row
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [5:0] result_row_index, [69:6] suggestion_bits, [71:70] zero
    output logic [thfs_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                 m_tlast        // last_result
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_AOWN,
        S_ASWEEP,
        S_ADRAIN,
        S_AWRITE,
        S_BOWN,
        S_BSWEEP,
        S_BDRAIN,
        S_BEMIT
    } state_t;

    typedef enum logic [2:0] {
        K_NONE,
        K_AOWN,
        K_AROW,
        K_BOWN,
        K_BROW
    } rd_kind_t;

    state_t                          state_reg;
    rd_kind_t                        rd_kind_reg;
    rd_kind_t                        rd_kind_next;
    logic [thfs_pkg::IDX_W-1:0]      rd_j_reg;
    logic [thfs_pkg::IDX_W-1:0]      i_reg;
    logic [thfs_pkg::IDX_W-1:0]      j_reg;
    logic [thfs_pkg::CNT_W-1:0]      node_count_reg;
    logic [thfs_pkg::NODE_W-1:0]     own_reg;
    logic [thfs_pkg::NODE_W-1:0]     acc_reg;
    logic                            out_valid_reg;
    logic [thfs_pkg::M_TDATA_W-1:0]  out_data_reg;
    logic                            out_last_reg;

    logic [thfs_pkg::NODE_W-1:0]     adj_mem [thfs_pkg::MAX_NODES];
    logic [thfs_pkg::NODE_W-1:0]     sug_mem [thfs_pkg::MAX_NODES];
    logic [thfs_pkg::NODE_W-1:0]     adj_rdata_reg;
    logic [thfs_pkg::NODE_W-1:0]     sug_rdata_reg;

    logic [thfs_pkg::CNT_W-1:0]      n_used;
    logic [thfs_pkg::CNT_W-1:0]      n_minus1;
    logic [thfs_pkg::IDX_W-1:0]      last_idx;
    logic [thfs_pkg::NODE_W-1:0]     node_mask;
    logic [thfs_pkg::NODE_W-1:0]     self_bit;
    logic [thfs_pkg::NODE_W-1:0]     two_hop;
    logic [thfs_pkg::IDX_W-1:0]      in_row;
    logic [thfs_pkg::NODE_W-1:0]     in_bits;
    logic                            in_beat;
    logic                            adj_we;
    logic [thfs_pkg::IDX_W-1:0]      adj_raddr;
    logic [thfs_pkg::IDX_W-1:0]      sug_raddr;
    logic                            out_free;

    always_comb begin
        if (node_count_reg == '0) begin
            n_used = thfs_pkg::CNT_W'(1);
        end else if (node_count_reg > thfs_pkg::CNT_W'(thfs_pkg::MAX_NODES)) begin
            n_used = thfs_pkg::CNT_W'(thfs_pkg::MAX_NODES);
        end else begin
            n_used = node_count_reg;
        end
        n_minus1 = n_used - thfs_pkg::CNT_W'(1);
        last_idx = n_minus1[thfs_pkg::IDX_W-1:0];
        for (int k = 0; k < thfs_pkg::NODE_W; k++) begin
            node_mask[k] = (thfs_pkg::CNT_W'(k) < n_used);
        end
    end

    always_comb begin
        case (state_reg)
            S_AOWN:   rd_kind_next = K_AOWN;
            S_ASWEEP: rd_kind_next = K_AROW;
            S_BOWN:   rd_kind_next = K_BOWN;
            S_BSWEEP: rd_kind_next = K_BROW;
            default:  rd_kind_next = K_NONE;
        endcase
    end

    assign self_bit  = thfs_pkg::NODE_W'(1) << i_reg;
    assign two_hop   = acc_reg & ~own_reg & ~self_bit & node_mask;
    assign in_row    = s_tdata[thfs_pkg::IDX_W-1:0];
    assign in_bits   = s_tdata[thfs_pkg::IDX_W +: thfs_pkg::NODE_W];
    assign s_tready  = (state_reg == S_LOAD);
    assign in_beat   = s_tvalid && s_tready;
    assign adj_we    = in_beat && ({1'b0, in_row} < thfs_pkg::CNT_W'(thfs_pkg::MAX_NODES));
    assign adj_raddr = (state_reg == S_AOWN) ? i_reg : j_reg;
    assign sug_raddr = (state_reg == S_BOWN) ? i_reg : j_reg;
    assign out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge aclk) begin
        if (adj_we) begin
            adj_mem[in_row] <= in_bits;
        end
        adj_rdata_reg <= adj_mem[adj_raddr];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_AWRITE) begin
            sug_mem[i_reg] <= two_hop;
        end
        sug_rdata_reg <= sug_mem[sug_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_LOAD;
            rd_kind_reg    <= K_NONE;
            node_count_reg <= thfs_pkg::NODE_COUNT_RESET;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                node_count_reg <= cfg_wr_data;
            end
            if (out_valid_reg && m_tready && (state_reg != S_BEMIT)) begin
                out_valid_reg <= 1'b0;
            end

            // consume the read issued last cycle
            case (rd_kind_reg)
                K_AOWN: own_reg <= adj_rdata_reg & node_mask;
                K_AROW: begin
                    if (own_reg[rd_j_reg] && (rd_j_reg != i_reg)) begin
                        acc_reg <= acc_reg | (adj_rdata_reg & node_mask);
                    end
                end
                K_BOWN: own_reg <= sug_rdata_reg;
                K_BROW: acc_reg[rd_j_reg] <= sug_rdata_reg[i_reg];
                default: ;
            endcase

            rd_kind_reg <= rd_kind_next;
            rd_j_reg    <= j_reg;

            case (state_reg)
                S_LOAD: begin
                    if (in_beat && s_tlast) begin
                        i_reg     <= '0;
                        state_reg <= S_AOWN;
                    end
                end
                S_AOWN: begin
                    j_reg     <= '0;
                    acc_reg   <= '0;
                    state_reg <= S_ASWEEP;
                end
                S_ASWEEP: begin
                    if (j_reg == last_idx) begin
                        state_reg <= S_ADRAIN;
                    end else begin
                        j_reg <= j_reg + thfs_pkg::IDX_W'(1);
                    end
                end
                S_ADRAIN: state_reg <= S_AWRITE;
                S_AWRITE: begin
                    if (i_reg == last_idx) begin
                        i_reg     <= '0;
                        state_reg <= S_BOWN;
                    end else begin
                        i_reg     <= i_reg + thfs_pkg::IDX_W'(1);
                        state_reg <= S_AOWN;
                    end
                end
                S_BOWN: begin
                    j_reg     <= '0;
                    acc_reg   <= '0;
                    state_reg <= S_BSWEEP;
                end
                S_BSWEEP: begin
                    if (j_reg == last_idx) begin
                        state_reg <= S_BDRAIN;
                    end else begin
                        j_reg <= j_reg + thfs_pkg::IDX_W'(1);
                    end
                end
                S_BDRAIN: state_reg <= S_BEMIT;
                S_BEMIT: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {2'b00, own_reg | acc_reg, i_reg};
                        out_last_reg  <= (i_reg == last_idx);
                        if (i_reg == last_idx) begin
                            state_reg <= S_LOAD;
                        end else begin
                            i_reg     <= i_reg + thfs_pkg::IDX_W'(1);
                            state_reg <= S_BOWN;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    a_last_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (state_reg == S_AOWN))
        else $error("last row beat did not start the two-hop pass");

    a_own_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_AOWN) |=> (rd_kind_reg == K_AOWN))
        else $error("own-row read tag lost");

    a_write_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_AWRITE) |-> (rd_kind_reg == K_NONE))
        else $error("two-hop row written with a read still in flight");

endmodule

`default_nettype wire

/* tb/two_hop_friend_suggestions_unit_tb.sv */
// Self-checking testbench for the two-hop friend suggestion unit.
`default_nettype none

module two_hop_friend_suggestions_unit_tb;

    localparam int SETTLE_CYCLES = 8;
    localparam int END_DRAIN_CYCLES =
        2 * (thfs_pkg::MAX_NODES + 1) * (thfs_pkg::MAX_NODES + 3);
    localparam int RANDOM_BEATS = 250;
    localparam int CYCLE_LIMIT = 4 * (RANDOM_BEATS + 250) *
        (2 * thfs_pkg::MAX_NODES * (thfs_pkg::MAX_NODES + 3) + thfs_pkg::MAX_NODES * 64);
    localparam int MAX_PRINTED = 20;

    typedef struct packed {
        logic [thfs_pkg::IDX_W-1:0]  node;
        logic [thfs_pkg::NODE_W-1:0] bits;
        logic                        last;
    } suggestion_t;

    typedef enum {FRAME_CLEAN, FRAME_NOISY, FRAME_EARLY_LAST, FRAME_FOREIGN_LAST} frame_kind_t;
    typedef enum {DENS_HALF, DENS_SPARSE, DENS_THIN, DENS_DENSE, DENS_PAIR} density_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [thfs_pkg::CNT_W-1:0]      cfg_wr_data = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [thfs_pkg::S_TDATA_W-1:0]  s_tdata = '0;   // [5:0] row_index, [69:6] friend_bits
    logic                            s_tlast = 1'b0; // last_row
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // [5:0] result_row_index, [69:6] suggestion_bits
    logic [thfs_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            m_tlast;        // last_result

    two_hop_friend_suggestions_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    logic [thfs_pkg::NODE_W-1:0] adj_rows [thfs_pkg::MAX_NODES];
    logic [thfs_pkg::NODE_W-1:0] rows_loaded = '0;
    logic [thfs_pkg::CNT_W-1:0]  node_count_model = thfs_pkg::NODE_COUNT_RESET;
    suggestion_t                 pending_suggestions [$];

    int  mismatches = 0;
    int  cycle_count = 0;
    int  beats_sent = 0;
    int  frames_sent = 0;
    int  rows_checked = 0;
    int  sink_left = 0;
    bit  send_idle = 1'b1;
    bit  sink_idle = 1'b1;

    always #5 aclk = ~aclk;

    function automatic int idle_cycles(bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic int nodes_in_use(logic [thfs_pkg::CNT_W-1:0] count);
        if (count == 0) return 1;
        if (count > thfs_pkg::MAX_NODES) return thfs_pkg::MAX_NODES;
        return int'(count);
    endfunction

    function automatic logic [thfs_pkg::NODE_W-1:0] node_mask(int n);
        if (n >= thfs_pkg::NODE_W) return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    function automatic logic [thfs_pkg::NODE_W-1:0] make_bits(density_t density);
        case (density)
            DENS_HALF:   return {$urandom, $urandom};
            DENS_SPARSE: return {$urandom, $urandom} & {$urandom, $urandom};
            DENS_THIN:   return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            DENS_DENSE:  return {$urandom, $urandom} | {$urandom, $urandom};
            default:     return (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
        endcase
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [thfs_pkg::NODE_W-1:0] got,
                                   input logic [thfs_pkg::NODE_W-1:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        end
    endtask

    // friends of friends, not friends, not self; then OR with the transpose
    task automatic predict_suggestions();
        logic [thfs_pkg::NODE_W-1:0] mask;
        logic [thfs_pkg::NODE_W-1:0] own;
        logic [thfs_pkg::NODE_W-1:0] reach;
        logic [thfs_pkg::NODE_W-1:0] row;
        logic [thfs_pkg::NODE_W-1:0] two_hop [thfs_pkg::MAX_NODES];
        suggestion_t expected_row;
        int n;
        n = nodes_in_use(node_count_model);
        mask = node_mask(n);
        for (int i = 0; i < n; i++) begin
            own = adj_rows[i] & mask;
            reach = '0;
            for (int j = 0; j < n; j++) begin
                if (j != i && own[j]) reach |= adj_rows[j] & mask;
            end
            two_hop[i] = reach & ~own & ~(64'd1 << i) & mask;
        end
        for (int i = 0; i < n; i++) begin
            row = two_hop[i];
            for (int j = 0; j < n; j++) begin
                if (two_hop[j][i]) row[j] = 1'b1;
            end
            expected_row = '{node: thfs_pkg::IDX_W'(i), bits: row, last: (i == n - 1)};
            pending_suggestions = {pending_suggestions, expected_row};
        end
    endtask

    task automatic send_row(input logic [thfs_pkg::IDX_W-1:0] idx,
                            input logic [thfs_pkg::NODE_W-1:0] bits,
                            input logic last);
        int gap;
        gap = idle_cycles(send_idle);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, bits, idx};
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        adj_rows[idx] = bits;
        rows_loaded[idx] = 1'b1;
        beats_sent++;
        if (last) predict_suggestions();
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_suggestions.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_node_count(input logic [thfs_pkg::CNT_W-1:0] value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        node_count_model = value;
    endtask

    task automatic send_frame(input int n, input frame_kind_t kind_in);
        logic [thfs_pkg::NODE_W-1:0] mat [thfs_pkg::MAX_NODES];
        logic [thfs_pkg::NODE_W-1:0] mask;
        density_t density;
        frame_kind_t kind;
        int last_at;
        kind = kind_in;
        mask = node_mask(n);
        density = density_t'($urandom_range(0, 4));
        for (int i = 0; i < thfs_pkg::MAX_NODES; i++) mat[i] = make_bits(density);
        if ($urandom_range(0, 1) == 1) begin
            for (int i = 0; i < n; i++) begin
                for (int j = 0; j < i; j++) mat[j][i] = mat[i][j];
            end
        end
        if (kind == FRAME_EARLY_LAST && (rows_loaded & mask) != mask) kind = FRAME_CLEAN;
        last_at = (kind == FRAME_EARLY_LAST) ? $urandom_range(0, n - 1) : n - 1;
        for (int i = 0; i <= last_at; i++) begin
            if (kind == FRAME_NOISY && $urandom_range(0, 3) == 0) begin
                send_row(thfs_pkg::IDX_W'($urandom_range(0, 63)), make_bits(density), 1'b0);
            end
            send_row(thfs_pkg::IDX_W'(i), mat[i], kind != FRAME_FOREIGN_LAST && i == last_at);
        end
        if (kind == FRAME_FOREIGN_LAST) begin
            send_row(thfs_pkg::IDX_W'(n < thfs_pkg::MAX_NODES ? $urandom_range(n, 63)
                                                              : $urandom_range(0, 63)),
                     make_bits(density), 1'b1);
        end
        frames_sent++;
    endtask

    task automatic test_single_node();
        set_node_count(thfs_pkg::CNT_W'(1));
        send_row(thfs_pkg::IDX_W'(0), '1, 1'b1);
        set_node_count(thfs_pkg::CNT_W'(0));
        send_row(thfs_pkg::IDX_W'(0), {$urandom, $urandom}, 1'b1);
    endtask

    task automatic test_path_graph();
        set_node_count(thfs_pkg::CNT_W'(3));
        send_row(thfs_pkg::IDX_W'(0), 64'hFFFF_FFFF_FFFF_FFF8 | 64'h2, 1'b0);
        send_row(thfs_pkg::IDX_W'(1), 64'hA5A5_0000_0000_0000 | 64'h5, 1'b0);
        send_row(thfs_pkg::IDX_W'(2), 64'h8000_0000_0000_0000 | 64'h2, 1'b1);
    endtask

    task automatic test_full_and_empty();
        set_node_count(thfs_pkg::CNT_W'(5));
        for (int i = 0; i < 5; i++) send_row(thfs_pkg::IDX_W'(i), '1, i == 4);
        for (int i = 0; i < 5; i++) send_row(thfs_pkg::IDX_W'(i), '0, i == 4);
    endtask

    task automatic test_directed_edges();
        set_node_count(thfs_pkg::CNT_W'(4));
        send_row(thfs_pkg::IDX_W'(0), 64'h2, 1'b0);
        send_row(thfs_pkg::IDX_W'(1), 64'h4, 1'b0);
        send_row(thfs_pkg::IDX_W'(2), 64'h8, 1'b0);
        send_row(thfs_pkg::IDX_W'(3), 64'h1, 1'b0);
        send_row(thfs_pkg::IDX_W'(40), {$urandom, $urandom}, 1'b1);
    endtask

    task automatic test_early_last();
        send_row(thfs_pkg::IDX_W'(1), 64'hD, 1'b1);
    endtask

    task automatic test_saturated_count();
        sink_idle = 1'b0;
        set_node_count(thfs_pkg::CNT_W'(127));
        send_frame(thfs_pkg::MAX_NODES, FRAME_CLEAN);
        sink_idle = 1'b1;
        set_node_count(thfs_pkg::CNT_W'(65));
        send_frame(thfs_pkg::MAX_NODES, FRAME_EARLY_LAST);
        set_node_count(thfs_pkg::CNT_W'(64));
        send_frame(thfs_pkg::MAX_NODES, FRAME_EARLY_LAST);
    endtask

    task automatic test_random_frames();
        int start;
        int r;
        frame_kind_t kind;
        start = beats_sent;
        while (beats_sent - start < RANDOM_BEATS) begin
            send_idle = ($urandom_range(0, 4) != 0);
            sink_idle = ($urandom_range(0, 4) != 0);
            // keep the setting now and then so loading follows the last result beat directly
            if ($urandom_range(0, 3) != 0) begin
                r = $urandom_range(0, 99);
                if (r < 4) set_node_count(thfs_pkg::CNT_W'(0));
                else if (r < 8) set_node_count(thfs_pkg::CNT_W'($urandom_range(65, 127)));
                else if (r < 70) set_node_count(thfs_pkg::CNT_W'($urandom_range(1, 10)));
                else if (r < 90) set_node_count(thfs_pkg::CNT_W'($urandom_range(11, 40)));
                else set_node_count(thfs_pkg::CNT_W'($urandom_range(41, 64)));
            end
            r = $urandom_range(0, 99);
            if (r < 65) kind = FRAME_CLEAN;
            else if (r < 80) kind = FRAME_NOISY;
            else if (r < 90) kind = FRAME_EARLY_LAST;
            else kind = FRAME_FOREIGN_LAST;
            send_frame(nodes_in_use(node_count_model), kind);
        end
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (sink_left > 0) begin
            sink_left--;
        end else if (m_tready && sink_idle) begin
            sink_left = idle_cycles(1'b1);
            if (sink_left > 0) begin
                m_tready <= 1'b0;
            end else begin
                sink_left = $urandom_range(0, 8);
            end
        end else begin
            m_tready <= 1'b1;
            sink_left = $urandom_range(0, 8);
        end
    end

    always @(posedge aclk) begin : check_results
        suggestion_t want;
        if (aresetn && m_tvalid && m_tready) begin
            rows_checked++;
            if (pending_suggestions.size() == 0) begin
                report_mismatch("result beat with nothing pending", m_tdata[69:6], '0);
            end else begin
                want = pending_suggestions.pop_front();
                if (m_tdata[5:0] !== want.node) begin
                    report_mismatch("result_row_index", 64'(m_tdata[5:0]), 64'(want.node));
                end
                if (m_tdata[69:6] !== want.bits) begin
                    report_mismatch("suggestion_bits", m_tdata[69:6], want.bits);
                end
                if (m_tlast !== want.last) begin
                    report_mismatch("last_result", 64'(m_tlast), 64'(want.last));
                end
                if (m_tdata[71:70] !== 2'b00) begin
                    report_mismatch("tdata padding", 64'(m_tdata[71:70]), '0);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_suggestions.size());
            $display("two_hop_friend_suggestions_unit_tb failed");
            $finish;
        end
    end

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_single_node();
        test_path_graph();
        test_full_and_empty();
        test_directed_edges();
        test_early_last();
        test_saturated_count();
        test_random_frames();
        wait_drained();
        repeat (END_DRAIN_CYCLES) @(negedge aclk);
        $display("covered %0d row beats in %0d frames, %0d suggestion rows checked",
                 beats_sent, frames_sent, rows_checked);
        $display("node counts zero to saturated, early and out-of-range last rows, random stalls");
        if (mismatches == 0) begin
            $display("two_hop_friend_suggestions_unit_tb passed");
        end else begin
            $display("two_hop_friend_suggestions_unit_tb failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
